[rtl/endstop_limit_calibration_sequencer_macros.svh]
// Assertion macros for the endstop limit calibration sequencer.
// Used by the top level; expects clk_i and rst_ni in the including scope.
`ifndef ENDSTOP_LIMIT_CALIBRATION_SEQUENCER_MACROS_SVH
`define ENDSTOP_LIMIT_CALIBRATION_SEQUENCER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ELCS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ELCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/elcs_pkg.sv]
// Shared types and constants of the endstop limit calibration sequencer.
// No dependencies.
`timescale 1ns / 1ps

package elcs_pkg;

  localparam int unsigned AngleW   = 32;
  localparam int unsigned DriveW   = 16;
  localparam int unsigned CurrentW = 15;
  localparam int unsigned CountW   = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_STALL_LIMIT   = 2'd0,
    CFG_SETTLE_TICKS  = 2'd1,
    CFG_DRIVE_CURRENT = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    STEP_YAW_MAX   = 3'd0,
    STEP_YAW_MIN   = 3'd1,
    STEP_PITCH_MAX = 3'd2,
    STEP_PITCH_MIN = 3'd3,
    STEP_END       = 3'd4
  } step_e;

  localparam logic [CountW-1:0]   StallLimitRst   = 16'd64;
  localparam logic [CountW-1:0]   SettleTicksRst  = 16'd200;
  localparam logic [CurrentW-1:0] DriveCurrentRst = 15'd5000;

endpackage

[rtl/elcs_if.sv]
// Valid/ready channel interfaces for the calibration sequencer items.
// Depends on elcs_pkg for field widths.
`timescale 1ns / 1ps

interface elcs_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [elcs_pkg::AngleW-1:0]    yaw_pos;
  logic signed [elcs_pkg::AngleW-1:0]    pitch_pos;

  modport source (output valid, output yaw_pos, output pitch_pos, input ready);
  modport sink   (input valid, input yaw_pos, input pitch_pos, output ready);
endinterface

interface elcs_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [elcs_pkg::DriveW-1:0]    yaw_drive;
  logic signed [elcs_pkg::DriveW-1:0]    pitch_drive;
  logic                                  calibrating;
  logic                                  finished;
  logic signed [elcs_pkg::AngleW-1:0]    yaw_center;
  logic signed [elcs_pkg::AngleW-1:0]    pitch_center;
  logic        [2:0]                     current_step;

  modport source (
    output valid, output yaw_drive, output pitch_drive, output calibrating,
    output finished, output yaw_center, output pitch_center, output current_step,
    input ready
  );
  modport sink (
    input valid, input yaw_drive, input pitch_drive, input calibrating,
    input finished, input yaw_center, input pitch_center, input current_step,
    output ready
  );
endinterface

[rtl/endstop_limit_calibration_sequencer.sv]
// Top level of the endstop limit calibration sequencer.
// Depends on elcs_pkg, elcs_if.sv and the assertion macro header.
`timescale 1ns / 1ps
`include "endstop_limit_calibration_sequencer_macros.svh"

// Usage:
//   in_i carries one control tick item: the yaw and pitch encoder angles.
//   out_o carries one result item per tick: drive commands for both axes,
//   the calibrating and finished flags, both axis centers and the step that
//   was in force during that tick.
//   The cfg_* port writes stall_limit (index 0), settle_ticks (index 1) and
//   drive_current (index 2); other indexes are ignored.
//   Latency: a result item is valid the cycle after its tick is accepted.
//   Throughput: one item per cycle while out_o is taken; the stall test,
//   hold counter and center adders sit between in_i and the result register.
//   A new item is accepted while the result register is empty or being
//   taken in the same cycle; when the receiver stalls, the result holds and
//   in_i.ready stays low until it is taken.
//   Reset clears the step to yaw max, the hold counter, previous angles and
//   recorded limits to zero, and loads the register reset values.
//   After the pitch min limit is recorded the block stays in the end step,
//   drives zero and reports the centers until the next reset.

module endstop_limit_calibration_sequencer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [elcs_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [elcs_pkg::CfgDataW-1:0]   cfg_data_i,
  elcs_in_if.sink                         in_i,
  elcs_out_if.source                      out_o
);
  import elcs_pkg::*;

  logic [CountW-1:0]   stall_limit_q;
  logic [CountW-1:0]   settle_ticks_q;
  logic [CurrentW-1:0] drive_current_q;

  step_e               step_q, step_d;
  logic [CountW-1:0]   hold_q, hold_d;
  logic [AngleW-1:0]   prev_yaw_q, prev_pitch_q;
  logic [AngleW-1:0]   yaw_upper_q, yaw_upper_d;
  logic [AngleW-1:0]   yaw_lower_q, yaw_lower_d;
  logic [AngleW-1:0]   pitch_upper_q, pitch_upper_d;
  logic [AngleW-1:0]   pitch_lower_q, pitch_lower_d;

  logic                out_valid_q;
  logic [DriveW-1:0]   yaw_drive_q, yaw_drive_d;
  logic [DriveW-1:0]   pitch_drive_q, pitch_drive_d;
  logic                calibrating_q, calibrating_d;
  logic                finished_q, finished_d;
  logic [AngleW-1:0]   yaw_center_q, yaw_center_d;
  logic [AngleW-1:0]   pitch_center_q, pitch_center_d;
  logic [2:0]          step_out_q, step_out_d;

  logic                in_acc;
  logic                axis_pitch;
  logic [AngleW-1:0]   angle_now, angle_prev;
  logic [AngleW:0]     diff, diff_abs;
  logic                stalled, settled;
  logic [CountW-1:0]   hold_inc;
  logic [DriveW-1:0]   drive_plus, drive_minus;
  logic [AngleW:0]     yaw_sum, pitch_sum;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  assign axis_pitch = (step_q == STEP_PITCH_MAX) || (step_q == STEP_PITCH_MIN);
  assign angle_now  = axis_pitch ? in_i.pitch_pos : in_i.yaw_pos;
  assign angle_prev = axis_pitch ? prev_pitch_q : prev_yaw_q;

  assign diff     = {angle_now[AngleW-1], angle_now} - {angle_prev[AngleW-1], angle_prev};
  assign diff_abs = diff[AngleW] ? (~diff + {{AngleW{1'b0}}, 1'b1}) : diff;
  assign stalled  = diff_abs < {{(AngleW + 1 - CountW){1'b0}}, stall_limit_q};
  assign hold_inc = (hold_q == {CountW{1'b1}}) ? hold_q : hold_q + {{(CountW-1){1'b0}}, 1'b1};
  assign settled  = stalled && (hold_inc > settle_ticks_q);

  assign drive_plus  = {1'b0, drive_current_q};
  assign drive_minus = ~drive_plus + {{(DriveW-1){1'b0}}, 1'b1};

  assign yaw_sum   = {yaw_upper_q[AngleW-1], yaw_upper_q}
                   + {yaw_lower_q[AngleW-1], yaw_lower_q};
  assign pitch_sum = {pitch_upper_q[AngleW-1], pitch_upper_q}
                   + {pitch_lower_q[AngleW-1], pitch_lower_q};

  always_comb begin
    step_d         = step_q;
    hold_d         = hold_q;
    yaw_upper_d    = yaw_upper_q;
    yaw_lower_d    = yaw_lower_q;
    pitch_upper_d  = pitch_upper_q;
    pitch_lower_d  = pitch_lower_q;
    yaw_drive_d    = '0;
    pitch_drive_d  = '0;
    calibrating_d  = 1'b1;
    finished_d     = 1'b0;
    yaw_center_d   = '0;
    pitch_center_d = '0;
    step_out_d     = step_q;

    if (step_q != STEP_END && step_q <= STEP_PITCH_MIN && stalled) begin
      hold_d = settled ? '0 : hold_inc;
    end

    unique case (step_q)
      STEP_YAW_MAX: begin
        yaw_drive_d = drive_plus;
        if (settled) begin
          yaw_upper_d = in_i.yaw_pos;
          step_d      = STEP_YAW_MIN;
        end
      end
      STEP_YAW_MIN: begin
        yaw_drive_d = drive_minus;
        if (settled) begin
          yaw_lower_d = in_i.yaw_pos;
          step_d      = STEP_PITCH_MAX;
        end
      end
      STEP_PITCH_MAX: begin
        pitch_drive_d = drive_plus;
        if (settled) begin
          pitch_upper_d = in_i.pitch_pos;
          step_d        = STEP_PITCH_MIN;
        end
      end
      STEP_PITCH_MIN: begin
        pitch_drive_d = drive_minus;
        if (settled) begin
          pitch_lower_d = in_i.pitch_pos;
          step_d        = STEP_END;
        end
      end
      default: begin
        step_d         = STEP_END;
        calibrating_d  = 1'b0;
        finished_d     = 1'b1;
        yaw_center_d   = yaw_sum[AngleW:1];
        pitch_center_d = pitch_sum[AngleW:1];
        step_out_d     = STEP_END;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_limit_q   <= StallLimitRst;
      settle_ticks_q  <= SettleTicksRst;
      drive_current_q <= DriveCurrentRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STALL_LIMIT:   stall_limit_q   <= cfg_data_i;
        CFG_SETTLE_TICKS:  settle_ticks_q  <= cfg_data_i;
        CFG_DRIVE_CURRENT: drive_current_q <= cfg_data_i[CurrentW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q        <= STEP_YAW_MAX;
      hold_q        <= '0;
      prev_yaw_q    <= '0;
      prev_pitch_q  <= '0;
      yaw_upper_q   <= '0;
      yaw_lower_q   <= '0;
      pitch_upper_q <= '0;
      pitch_lower_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (in_acc) begin
        step_q        <= step_d;
        hold_q        <= hold_d;
        prev_yaw_q    <= in_i.yaw_pos;
        prev_pitch_q  <= in_i.pitch_pos;
        yaw_upper_q   <= yaw_upper_d;
        yaw_lower_q   <= yaw_lower_d;
        pitch_upper_q <= pitch_upper_d;
        pitch_lower_q <= pitch_lower_d;
        out_valid_q   <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      yaw_drive_q    <= yaw_drive_d;
      pitch_drive_q  <= pitch_drive_d;
      calibrating_q  <= calibrating_d;
      finished_q     <= finished_d;
      yaw_center_q   <= yaw_center_d;
      pitch_center_q <= pitch_center_d;
      step_out_q     <= step_out_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.yaw_drive    = yaw_drive_q;
  assign out_o.pitch_drive  = pitch_drive_q;
  assign out_o.calibrating  = calibrating_q;
  assign out_o.finished     = finished_q;
  assign out_o.yaw_center   = yaw_center_q;
  assign out_o.pitch_center = pitch_center_q;
  assign out_o.current_step = step_out_q;

  `ELCS_ASSERT_SAME(a_flags_exclusive, out_valid_q, finished_q != calibrating_q, "flags disagree")
  `ELCS_ASSERT_NEXT(a_end_sticky, in_acc && step_q == STEP_END, step_q == STEP_END, "left end")
  `ELCS_ASSERT_NEXT(a_step_by_one, in_acc,
                    $stable(step_q) || (step_q == $past(step_q) + 3'd1), "step skipped")
  `ELCS_ASSERT_NEXT(a_hold_cleared, in_acc, $stable(step_q) || hold_q == '0, "hold kept")

endmodule

[dv/tb_endstop_limit_calibration_sequencer.sv]
// Self-checking testbench for endstop_limit_calibration_sequencer: drives encoder ticks,
// predicts every result item and compares it field by field against the block.
// Depends on elcs_pkg and the channel interfaces in elcs_if.sv.
`timescale 1ns / 1ps

module tb_endstop_limit_calibration_sequencer;
  import elcs_pkg::*;

  localparam logic signed [AngleW-1:0] AngleMax    = 32'sh7FFF_FFFF;
  localparam logic signed [AngleW-1:0] AngleMin    = 32'sh8000_0000;
  localparam logic [CfgIdxW-1:0]       CfgIdxSpare = 2'd3;
  localparam logic [CfgDataW-1:0]      CurrentMax  = 16'd32767;
  localparam logic [CfgDataW-1:0]      SettleMax   = 16'd65534;
  localparam logic [CfgDataW-1:0]      StallMax    = 16'd65535;
  localparam int unsigned              QuietLimit  = 5000;

  typedef struct packed {
    logic signed [AngleW-1:0] yaw;
    logic signed [AngleW-1:0] pitch;
  } tick_t;

  typedef struct packed {
    logic signed [DriveW-1:0] yaw_drive;
    logic signed [DriveW-1:0] pitch_drive;
    logic                     calibrating;
    logic                     finished;
    logic signed [AngleW-1:0] yaw_center;
    logic signed [AngleW-1:0] pitch_center;
    step_e                    step;
  } report_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  elcs_in_if  tick_if ();
  elcs_out_if report_if ();

  endstop_limit_calibration_sequencer dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (tick_if),
    .out_o     (report_if)
  );

  always #10 clk_i = ~clk_i;

  // Predicted block state and registers.
  logic [CountW-1:0]        m_stall  = StallLimitRst;
  logic [CountW-1:0]        m_settle = SettleTicksRst;
  logic [CurrentW-1:0]      m_drive  = DriveCurrentRst;
  step_e                    m_step   = STEP_YAW_MAX;
  logic [CountW-1:0]        m_hold   = '0;
  logic signed [AngleW-1:0] m_prev_yaw   = '0;
  logic signed [AngleW-1:0] m_prev_pitch = '0;
  logic signed [AngleW-1:0] m_yaw_hi     = '0;
  logic signed [AngleW-1:0] m_yaw_lo     = '0;
  logic signed [AngleW-1:0] m_pitch_hi   = '0;
  logic signed [AngleW-1:0] m_pitch_lo   = '0;

  tick_t       pending_ticks[$];
  report_t     expected_reports[$];
  int unsigned ticks_queued  = 0;
  int unsigned reports_seen  = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  logic        tick_taken    = 1'b0;
  logic signed [AngleW-1:0] gen_yaw   = '0;
  logic signed [AngleW-1:0] gen_pitch = '0;
  tick_t       next_tick;

  function automatic logic hold_expired(logic signed [AngleW-1:0] now,
                                        logic signed [AngleW-1:0] prior);
    longint delta;
    delta = longint'(now) - longint'(prior);
    if (delta < 0) delta = -delta;
    if (delta < longint'(m_stall)) begin
      if (m_hold != '1) m_hold = m_hold + 1'b1;
      if (m_hold > m_settle) begin
        m_hold = '0;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic signed [AngleW-1:0] midpoint(logic signed [AngleW-1:0] hi,
                                                        logic signed [AngleW-1:0] lo);
    longint sum;
    sum = longint'(hi) + longint'(lo);
    return sum[AngleW:1];
  endfunction

  function automatic report_t predict_report(tick_t t);
    report_t r;
    logic signed [DriveW-1:0] plus;
    r = '0;
    plus = {1'b0, m_drive};
    r.step = m_step;
    case (m_step)
      STEP_YAW_MAX: begin
        r.yaw_drive = plus;
        r.calibrating = 1'b1;
        if (hold_expired(t.yaw, m_prev_yaw)) begin
          m_yaw_hi = t.yaw;
          m_step = STEP_YAW_MIN;
        end
      end
      STEP_YAW_MIN: begin
        r.yaw_drive = -plus;
        r.calibrating = 1'b1;
        if (hold_expired(t.yaw, m_prev_yaw)) begin
          m_yaw_lo = t.yaw;
          m_step = STEP_PITCH_MAX;
        end
      end
      STEP_PITCH_MAX: begin
        r.pitch_drive = plus;
        r.calibrating = 1'b1;
        if (hold_expired(t.pitch, m_prev_pitch)) begin
          m_pitch_hi = t.pitch;
          m_step = STEP_PITCH_MIN;
        end
      end
      STEP_PITCH_MIN: begin
        r.pitch_drive = -plus;
        r.calibrating = 1'b1;
        if (hold_expired(t.pitch, m_prev_pitch)) begin
          m_pitch_lo = t.pitch;
          m_step = STEP_END;
        end
      end
      default: begin
        r.step = STEP_END;
        m_step = STEP_END;
        r.finished = 1'b1;
        r.yaw_center = midpoint(m_yaw_hi, m_yaw_lo);
        r.pitch_center = midpoint(m_pitch_hi, m_pitch_lo);
      end
    endcase
    m_prev_yaw = t.yaw;
    m_prev_pitch = t.pitch;
    return r;
  endfunction

  function automatic void note_mismatch(string what, longint want_v, longint got_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t %s: expected %0d, got %0d", $time, what, want_v, got_v);
  endfunction

  // Next angle of a random walk: in stall_pct percent of calls a move below the stall limit
  // or sometimes exactly at it, else a jump, often to the ends of the range.
  function automatic logic signed [AngleW-1:0] walk(logic signed [AngleW-1:0] from,
                                                    int unsigned stall_pct);
    longint lim;
    longint p;
    lim = longint'(m_stall);
    p = longint'(from);
    if ($urandom_range(99) < stall_pct) begin
      case ($urandom_range(9))
        0: p = p + lim;
        1: p = p - lim;
        default: if (lim > 1) p = p + longint'($urandom_range(32'(2 * lim - 2))) - (lim - 1);
      endcase
    end else begin
      case ($urandom_range(3))
        0: p = longint'(AngleMax);
        1: p = longint'(AngleMin);
        default: p = longint'($signed($urandom()));
      endcase
    end
    if (p > longint'(AngleMax)) p = longint'(AngleMax);
    if (p < longint'(AngleMin)) p = longint'(AngleMin);
    return p[AngleW-1:0];
  endfunction

  function automatic void push_tick(logic signed [AngleW-1:0] yaw,
                                    logic signed [AngleW-1:0] pitch);
    tick_t t;
    t.yaw = yaw;
    t.pitch = pitch;
    pending_ticks.push_back(t);
    ticks_queued++;
    gen_yaw = yaw;
    gen_pitch = pitch;
  endfunction

  function automatic void push_walk(int unsigned count, int unsigned stall_pct);
    for (int unsigned i = 0; i < count; i++)
      push_tick(walk(gen_yaw, stall_pct), walk(gen_pitch, stall_pct));
  endfunction

  task automatic wait_drain();
    while (reports_seen != ticks_queued) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    case (idx)
      CFG_STALL_LIMIT:   m_stall = data;
      CFG_SETTLE_TICKS:  m_settle = data;
      CFG_DRIVE_CURRENT: m_drive = data[CurrentW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Driver: hold the item until taken, then present the next one unless idling.
  always @(negedge clk_i) begin
    if (!tick_if.valid || tick_taken) begin
      if (rst_ni && pending_ticks.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        next_tick = pending_ticks.pop_front();
        tick_if.valid <= 1'b1;
        tick_if.yaw_pos <= next_tick.yaw;
        tick_if.pitch_pos <= next_tick.pitch;
      end else begin
        tick_if.valid <= 1'b0;
      end
    end
    report_if.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Monitor: check results against the oldest prediction, predict each accepted tick.
  always @(posedge clk_i) begin
    report_t want;
    tick_t   seen;
    tick_taken = rst_ni && tick_if.valid && tick_if.ready;
    if (rst_ni && report_if.valid && report_if.ready) begin
      if (expected_reports.size() == 0) begin
        note_mismatch("result item with nothing pending", 0, 0);
      end else begin
        want = expected_reports.pop_front();
        reports_seen++;
        if (want.yaw_drive !== report_if.yaw_drive)
          note_mismatch("yaw_drive", want.yaw_drive, report_if.yaw_drive);
        if (want.pitch_drive !== report_if.pitch_drive)
          note_mismatch("pitch_drive", want.pitch_drive, report_if.pitch_drive);
        if (want.calibrating !== report_if.calibrating)
          note_mismatch("calibrating", want.calibrating, report_if.calibrating);
        if (want.finished !== report_if.finished)
          note_mismatch("finished", want.finished, report_if.finished);
        if (want.yaw_center !== report_if.yaw_center)
          note_mismatch("yaw_center", want.yaw_center, report_if.yaw_center);
        if (want.pitch_center !== report_if.pitch_center)
          note_mismatch("pitch_center", want.pitch_center, report_if.pitch_center);
        if (want.step !== report_if.current_step)
          note_mismatch("current_step", want.step, report_if.current_step);
      end
    end
    if (tick_taken) begin
      seen.yaw = tick_if.yaw_pos;
      seen.pitch = tick_if.pitch_pos;
      expected_reports.push_back(predict_report(seen));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((tick_if.valid && tick_if.ready) || (report_if.valid && report_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles == QuietLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    logic [CfgDataW-1:0] stall_pick;
    logic [CfgDataW-1:0] drive_pick;
    tick_if.valid = 1'b0;
    tick_if.yaw_pos = '0;
    tick_if.pitch_pos = '0;
    report_if.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_STALL_LIMIT;
    cfg_data = '0;
    rst_ni = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset register values; first tick compares against zero, stall limit edges,
    // full-range swings that wrap on 32 bits.
    push_tick(0, 0);
    push_tick(63, -63);
    push_tick(127, 1);
    push_tick(AngleMin, AngleMax);
    push_tick(AngleMax, AngleMin);
    push_tick(AngleMax, AngleMin);
    push_tick(AngleMax - 63, AngleMin + 64);
    push_tick(-1, 32'sh5555_5555);
    push_tick(32'shAAAA_AAAA, -1);
    wait_drain();

    // Zero stall limit: nothing counts as stalled, even a repeated angle.
    src_idle_pct = 29;
    snk_stall_pct = 29;
    write_reg(CFG_STALL_LIMIT, '0);
    write_reg(CFG_SETTLE_TICKS, '0);
    write_reg(CFG_DRIVE_CURRENT, CurrentMax);
    write_reg(CfgIdxSpare, '1);
    push_tick(AngleMax, AngleMax);
    push_tick(AngleMax, AngleMax);
    push_tick(AngleMax, AngleMax);
    push_tick(0, 0);
    push_tick(0, 0);
    push_tick(1, 1);
    wait_drain();

    // Largest settle count: the hold counter climbs without finishing the step.
    src_idle_pct = 0;
    snk_stall_pct = 0;
    write_reg(CFG_STALL_LIMIT, StallMax);
    write_reg(CFG_SETTLE_TICKS, SettleMax);
    write_reg(CFG_DRIVE_CURRENT, '0);
    push_walk(100, 100);
    wait_drain();

    for (int unsigned chunk = 0; chunk < 8; chunk++) begin
      case (chunk % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 76; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 76; end
        default: begin src_idle_pct = 29; snk_stall_pct = 29; end
      endcase
      case ($urandom_range(3))
        0: stall_pick = 16'd1;
        1: stall_pick = StallMax;
        default: stall_pick = 16'($urandom_range(4096, 1));
      endcase
      case ($urandom_range(3))
        0: drive_pick = '0;
        1: drive_pick = CurrentMax;
        default: drive_pick = 16'($urandom_range(32767));
      endcase
      if (chunk == 0) drive_pick = CurrentMax;
      write_reg(CFG_STALL_LIMIT, stall_pick);
      write_reg(CFG_SETTLE_TICKS, (chunk == 7) ? 16'd0 : 16'($urandom_range(60)));
      write_reg(CFG_DRIVE_CURRENT, drive_pick);
      push_walk(125, (chunk == 7) ? 80 : 50);
      wait_drain();
    end

    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0 && expected_reports.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
